/* src/two_wire_sensor_serial_master_core_defines.svh */
// assertion macros shared by the checker of the two-wire serial master
// needs clk and arst_n in scope where the macros are used
`ifndef TWO_WIRE_SENSOR_SERIAL_MASTER_CORE_DEFINES_SVH
`define TWO_WIRE_SENSOR_SERIAL_MASTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TWSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/twss_pkg.sv */
// shared types and constants of the two-wire serial master
// no dependencies
`default_nettype none

package twss_pkg;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_CLOCK_HALF   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOLD_WAIT    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RELEASE_WAIT = 2'd2;
	localparam int unsigned CfgDataW = 16;

	// register reset values
	localparam logic [7:0]  CLOCK_HALF_RST   = 8'd8;
	localparam logic [15:0] HOLD_WAIT_RST    = 16'd320;
	localparam logic [15:0] RELEASE_WAIT_RST = 16'd1280;

	// frame layout
	localparam int unsigned WRITE_FLAG_BIT = 15;
	localparam logic [4:0]  WRITE_BITS     = 5'd16;
	localparam logic [4:0]  BYTE_BITS      = 5'd8;

	// sequencer phases, one-hot
	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_OUT_LO  = 7'b0000010,
		PH_OUT_HI  = 7'b0000100,
		PH_HOLD    = 7'b0001000,
		PH_RELEASE = 7'b0010000,
		PH_IN_LO   = 7'b0100000,
		PH_IN_HI   = 7'b1000000
	} phase_t;

	// timing configuration seen by the sequencer
	typedef struct packed {
		logic [7:0]  clock_half;
		logic [15:0] hold_wait;
		logic [15:0] rel_wait;
	} cfg_t;

	// one access word as presented to the sequencer
	typedef struct packed {
		logic       start_req;
		logic       func;
		logic [6:0] reg_address;
		logic [7:0] write_data;
		logic       data_pin_in;
	} req_t;

	// pin levels and status after a tick
	typedef struct packed {
		logic       clock_pin;
		logic       data_pin_out;
		logic       data_drive;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
	} status_t;

endpackage

`default_nettype wire

/* src/twss_cfg.sv */
// configuration registers of the two-wire serial master
// depends on twss_pkg
`default_nettype none

module twss_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [twss_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [twss_pkg::CfgDataW-1:0] cfg_data,
	output twss_pkg::cfg_t                     cfg
);

	logic [7:0]  clock_half_q;
	logic [15:0] hold_wait_q;
	logic [15:0] rel_wait_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_half_q <= twss_pkg::CLOCK_HALF_RST;
			hold_wait_q  <= twss_pkg::HOLD_WAIT_RST;
			rel_wait_q   <= twss_pkg::RELEASE_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				twss_pkg::CFG_CLOCK_HALF:   clock_half_q <= cfg_data[7:0];
				twss_pkg::CFG_HOLD_WAIT:    hold_wait_q  <= cfg_data;
				twss_pkg::CFG_RELEASE_WAIT: rel_wait_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.clock_half = clock_half_q;
	assign cfg.hold_wait  = hold_wait_q;
	assign cfg.rel_wait   = rel_wait_q;

endmodule

`default_nettype wire

/* src/twss_engine.sv */
// tick sequencer of the two-wire serial master: phase, counters, shifters, pins
// depends on twss_pkg
`default_nettype none

module twss_engine (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire twss_pkg::req_t  req,
	input  wire twss_pkg::cfg_t  cfg,
	output twss_pkg::status_t status
);

	twss_pkg::phase_t phase_q, phase_d;
	logic [4:0]  bits_q, bits_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] oshift_q, oshift_d;
	logic [7:0]  ishift_q, ishift_d;
	logic [7:0]  last_q, last_d;
	logic        clk_q, clk_d;
	logic        dat_q, dat_d;
	logic        drv_q, drv_d;
	logic        wr_q, wr_d;
	logic        done_q, done_d;

	logic [7:0]  half;
	logic        half_end;
	logic [4:0]  bits_dec;
	logic [15:0] oshift_nx;
	logic [7:0]  ishift_nx;
	logic [15:0] tick_inc;

	// zero half period behaves as one tick
	assign half      = (cfg.clock_half == 8'd0) ? 8'd1 : cfg.clock_half;
	assign half_end  = (tick_q >= {8'd0, half});
	assign bits_dec  = (bits_q != 5'd0) ? (bits_q - 5'd1) : 5'd0;
	assign oshift_nx = {oshift_q[14:0], 1'b0};
	assign ishift_nx = {ishift_q[6:0], req.data_pin_in};
	assign tick_inc  = tick_q + 16'd1;

	// next-state logic for one tick
	always_comb begin
		phase_d  = phase_q;
		bits_d   = bits_q;
		tick_d   = tick_q;
		oshift_d = oshift_q;
		ishift_d = ishift_q;
		last_d   = last_q;
		clk_d    = clk_q;
		dat_d    = dat_q;
		drv_d    = drv_q;
		wr_d     = wr_q;
		done_d   = 1'b0;
		case (phase_q)
			twss_pkg::PH_IDLE: begin
				if (req.start_req) begin
					wr_d     = req.func;
					ishift_d = 8'd0;
					if (req.func) begin
						oshift_d = {1'b1, req.reg_address, req.write_data};
						bits_d   = twss_pkg::WRITE_BITS;
					end else begin
						oshift_d = {1'b0, req.reg_address, 8'd0};
						bits_d   = twss_pkg::BYTE_BITS;
					end
					phase_d = twss_pkg::PH_OUT_LO;
					tick_d  = 16'd1;
					clk_d   = 1'b0;
					dat_d   = req.func;
					drv_d   = 1'b1;
				end
			end
			twss_pkg::PH_OUT_LO: begin
				if (half_end) begin
					phase_d = twss_pkg::PH_OUT_HI;
					tick_d  = 16'd1;
					clk_d   = 1'b1;
					drv_d   = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			twss_pkg::PH_OUT_HI: begin
				if (half_end) begin
					oshift_d = oshift_nx;
					bits_d   = bits_dec;
					if (bits_dec != 5'd0) begin
						// next address or data bit
						phase_d = twss_pkg::PH_OUT_LO;
						tick_d  = 16'd1;
						clk_d   = 1'b0;
						dat_d   = oshift_nx[twss_pkg::WRITE_FLAG_BIT];
						drv_d   = 1'b1;
					end else if (wr_q) begin
						phase_d = twss_pkg::PH_IDLE;
						tick_d  = 16'd0;
						bits_d  = 5'd0;
						clk_d   = 1'b1;
						drv_d   = 1'b1;
						done_d  = 1'b1;
					end else if (cfg.hold_wait != 16'd0) begin
						phase_d = twss_pkg::PH_HOLD;
						tick_d  = 16'd1;
						clk_d   = 1'b1;
						drv_d   = 1'b1;
					end else if (cfg.rel_wait != 16'd0) begin
						phase_d = twss_pkg::PH_RELEASE;
						tick_d  = 16'd1;
						clk_d   = 1'b1;
						drv_d   = 1'b0;
					end else begin
						bits_d  = twss_pkg::BYTE_BITS;
						phase_d = twss_pkg::PH_IN_LO;
						tick_d  = 16'd1;
						clk_d   = 1'b0;
						drv_d   = 1'b0;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			twss_pkg::PH_HOLD: begin
				if (tick_q >= cfg.hold_wait) begin
					if (cfg.rel_wait != 16'd0) begin
						phase_d = twss_pkg::PH_RELEASE;
						tick_d  = 16'd1;
						clk_d   = 1'b1;
						drv_d   = 1'b0;
					end else begin
						bits_d  = twss_pkg::BYTE_BITS;
						phase_d = twss_pkg::PH_IN_LO;
						tick_d  = 16'd1;
						clk_d   = 1'b0;
						drv_d   = 1'b0;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			twss_pkg::PH_RELEASE: begin
				if (tick_q >= cfg.rel_wait) begin
					bits_d  = twss_pkg::BYTE_BITS;
					phase_d = twss_pkg::PH_IN_LO;
					tick_d  = 16'd1;
					clk_d   = 1'b0;
					drv_d   = 1'b0;
				end else begin
					tick_d = tick_inc;
				end
			end
			twss_pkg::PH_IN_LO: begin
				if (half_end) begin
					phase_d = twss_pkg::PH_IN_HI;
					tick_d  = 16'd1;
					clk_d   = 1'b1;
					drv_d   = 1'b0;
				end else begin
					tick_d = tick_inc;
				end
			end
			twss_pkg::PH_IN_HI: begin
				if (half_end) begin
					// sample as the clock falls again
					ishift_d = ishift_nx;
					bits_d   = bits_dec;
					if (bits_dec != 5'd0) begin
						phase_d = twss_pkg::PH_IN_LO;
						tick_d  = 16'd1;
						clk_d   = 1'b0;
						drv_d   = 1'b0;
					end else begin
						last_d  = ishift_nx;
						phase_d = twss_pkg::PH_IDLE;
						tick_d  = 16'd0;
						bits_d  = 5'd0;
						clk_d   = 1'b1;
						drv_d   = 1'b1;
						done_d  = 1'b1;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				phase_d = twss_pkg::PH_IDLE;
				tick_d  = 16'd0;
				bits_d  = 5'd0;
				clk_d   = 1'b1;
				drv_d   = 1'b1;
			end
		endcase
	end

	// state update, one tick per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= twss_pkg::PH_IDLE;
			bits_q   <= 5'd0;
			tick_q   <= 16'd0;
			oshift_q <= 16'd0;
			ishift_q <= 8'd0;
			last_q   <= 8'd0;
			clk_q    <= 1'b1;
			dat_q    <= 1'b0;
			drv_q    <= 1'b1;
			wr_q     <= 1'b0;
			done_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			bits_q   <= bits_d;
			tick_q   <= tick_d;
			oshift_q <= oshift_d;
			ishift_q <= ishift_d;
			last_q   <= last_d;
			clk_q    <= clk_d;
			dat_q    <= dat_d;
			drv_q    <= drv_d;
			wr_q     <= wr_d;
			done_q   <= done_d;
		end
	end

	assign status.clock_pin    = clk_q;
	assign status.data_pin_out = dat_q;
	assign status.data_drive   = drv_q;
	assign status.busy         = (phase_q != twss_pkg::PH_IDLE);
	assign status.done         = done_q;
	assign status.read_data    = last_q;

endmodule

`default_nettype wire

/* src/two_wire_sensor_serial_master_core.sv */
// top level of the two-wire serial master: input register, sequencer, result handshake
// depends on twss_pkg, twss_cfg, twss_engine
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+----------------------------------------
//   in       | sink      | in_valid / in_stall   | start_req func reg_address write_data
//            |           |                      | data_pin_in
//   out      | source    | out_valid / out_stall | clock_pin data_pin_out data_drive busy_res
//            |           |                      | done_res read_data
//   cfg      | sink      | cfg_we                | cfg_index cfg_data
//
// each input word is one tick of the pin sequencer; one word a cycle is taken while the
// output does not stall; its result word passes the input register, then the sequencer state
// the sequencer state doubles as the result register, so it steps only when the
// result slot is free or being taken
// a stalled output holds the input register; in_stall rises only when it is full
// reset puts the link idle with the clock high and the data line driven low
`default_nettype none

module two_wire_sensor_serial_master_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [twss_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [twss_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          start_req,
	input  wire logic                          func,
	input  wire logic [6:0]                    reg_address,
	input  wire logic [7:0]                    write_data,
	input  wire logic                          data_pin_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               clock_pin,
	output logic                               data_pin_out,
	output logic                               data_drive,
	output logic                               busy_res,
	output logic                               done_res,
	output logic [7:0]                         read_data
);

	twss_pkg::cfg_t    cfg;
	twss_pkg::req_t    req_s1;
	twss_pkg::status_t status;
	logic              valid_s1;
	logic              out_valid_q;
	logic              slot_free;
	logic              step;
	logic              in_take;

	twss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake control
	assign slot_free = !out_valid_q || !out_stall;
	assign step      = valid_s1 && slot_free;
	assign in_stall  = valid_s1 && !slot_free;
	assign in_take   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.start_req   <= start_req;
			req_s1.func        <= func;
			req_s1.reg_address <= reg_address;
			req_s1.write_data  <= write_data;
			req_s1.data_pin_in <= data_pin_in;
		end
	end

	twss_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req_s1),
		.cfg    (cfg),
		.status (status)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign clock_pin    = status.clock_pin;
	assign data_pin_out = status.data_pin_out;
	assign data_drive   = status.data_drive;
	assign busy_res     = status.busy;
	assign done_res     = status.done;
	assign read_data    = status.read_data;

endmodule

`default_nettype wire

/* src/twss_checker.sv */
// port-level checks of the two-wire serial master, bound to the top level
// depends on two_wire_sensor_serial_master_core_defines.svh
`default_nettype none
`include "two_wire_sensor_serial_master_core_defines.svh"

module twss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       clock_pin,
	input wire logic       data_pin_out,
	input wire logic       data_drive,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [7:0] read_data
);

	// a finishing tick leaves the link idle
	`TWSS_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "done while busy")

	// idle link has clock high and line driven
	`TWSS_ASSERT_NOW(a_idle_pins, out_valid && !busy_res, clock_pin && data_drive, "bad idle pins")

	// the line is only released inside a read
	`TWSS_ASSERT_NOW(a_release_busy, out_valid && !data_drive, busy_res, "released while idle")

	// a stalled word holds
	`TWSS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
		out_valid && $stable(clock_pin) && $stable(data_pin_out) && $stable(read_data),
		"stalled word changed")

endmodule

bind two_wire_sensor_serial_master_core twss_checker u_twss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.clock_pin    (clock_pin),
	.data_pin_out (data_pin_out),
	.data_drive   (data_drive),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.read_data    (read_data)
);

`default_nettype wire

/* tb/twss_link_checker.sv */
// checker for the two-wire serial master: watches the config port and both word channels,
// predicts every result word from its own copy of the pin sequencer and compares field by field
// depends on twss_pkg
module twss_link_checker
	import twss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                start_req,
	input  logic                func,
	input  logic [6:0]          reg_address,
	input  logic [7:0]          write_data,
	input  logic                data_pin_in,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                clock_pin,
	input  logic                data_pin_out,
	input  logic                data_drive,
	input  logic                busy_res,
	input  logic                done_res,
	input  logic [7:0]          read_data,
	output int unsigned         fail_count,
	output int unsigned         pending
);

	// timing registers as the sequencer sees them
	logic [7:0]  clock_half;
	logic [15:0] hold_wait;
	logic [15:0] rel_wait;

	// sequencer state
	phase_t      link_phase;
	logic [4:0]  bits_left;
	logic [15:0] ticks;
	logic [15:0] frame;
	logic [7:0]  in_byte;
	logic [7:0]  last_byte;
	logic        clk_lvl;
	logic        data_lvl;
	logic        drive_lvl;
	logic        is_wr;

	status_t     pin_status_q[$];
	int unsigned mismatch_total;

	initial begin
		fail_count = 0;
		pending = 0;
		mismatch_total = 0;
	end

	// clock low with the current frame bit on the line
	task automatic link_out_low();
		link_phase = PH_OUT_LO;
		ticks = 16'd1;
		clk_lvl = 1'b0;
		data_lvl = frame[WRITE_FLAG_BIT];
		drive_lvl = 1'b1;
	endtask

	// clock low with the line released
	task automatic link_in_low();
		link_phase = PH_IN_LO;
		ticks = 16'd1;
		clk_lvl = 1'b0;
		drive_lvl = 1'b0;
	endtask

	// release the line; a zero wait goes straight to the read bits
	task automatic link_release();
		clk_lvl = 1'b1;
		drive_lvl = 1'b0;
		if (rel_wait == 16'd0) begin
			bits_left = BYTE_BITS;
			link_in_low();
		end else begin
			link_phase = PH_RELEASE;
			ticks = 16'd1;
		end
	endtask

	// back to idle, line driven at its last level
	task automatic link_finish();
		link_phase = PH_IDLE;
		ticks = 16'd0;
		bits_left = 5'd0;
		clk_lvl = 1'b1;
		drive_lvl = 1'b1;
	endtask

	// one tick of the sequencer
	task automatic advance_link(input req_t w, output status_t s);
		logic [7:0] half;
		logic       done;
		half = (clock_half == 8'd0) ? 8'd1 : clock_half;
		done = 1'b0;
		case (link_phase)
			PH_IDLE: begin
				if (w.start_req) begin
					is_wr = w.func;
					in_byte = 8'd0;
					if (w.func) begin
						frame = {1'b1, w.reg_address, w.write_data};
						bits_left = WRITE_BITS;
					end else begin
						frame = {1'b0, w.reg_address, 8'd0};
						bits_left = BYTE_BITS;
					end
					link_out_low();
				end
			end
			PH_OUT_LO: begin
				if (ticks >= half) begin
					link_phase = PH_OUT_HI;
					ticks = 16'd1;
					clk_lvl = 1'b1;
					drive_lvl = 1'b1;
				end else begin
					ticks++;
				end
			end
			PH_OUT_HI: begin
				if (ticks >= half) begin
					frame = frame << 1;
					bits_left = (bits_left != 5'd0) ? bits_left - 5'd1 : 5'd0;
					if (bits_left != 5'd0) begin
						link_out_low();
					end else if (is_wr) begin
						link_finish();
						done = 1'b1;
					end else if (hold_wait == 16'd0) begin
						link_release();
					end else begin
						link_phase = PH_HOLD;
						ticks = 16'd1;
						clk_lvl = 1'b1;
						drive_lvl = 1'b1;
					end
				end else begin
					ticks++;
				end
			end
			PH_HOLD: begin
				if (ticks >= hold_wait) link_release();
				else ticks++;
			end
			PH_RELEASE: begin
				if (ticks >= rel_wait) begin
					bits_left = BYTE_BITS;
					link_in_low();
				end else begin
					ticks++;
				end
			end
			PH_IN_LO: begin
				if (ticks >= half) begin
					link_phase = PH_IN_HI;
					ticks = 16'd1;
					clk_lvl = 1'b1;
					drive_lvl = 1'b0;
				end else begin
					ticks++;
				end
			end
			PH_IN_HI: begin
				if (ticks >= half) begin
					// sampled on the tick the clock falls again
					in_byte = {in_byte[6:0], w.data_pin_in};
					bits_left = (bits_left != 5'd0) ? bits_left - 5'd1 : 5'd0;
					if (bits_left != 5'd0) begin
						link_in_low();
					end else begin
						last_byte = in_byte;
						link_finish();
						done = 1'b1;
					end
				end else begin
					ticks++;
				end
			end
			default: link_finish();
		endcase
		s.clock_pin = clk_lvl;
		s.data_pin_out = data_lvl;
		s.data_drive = drive_lvl;
		s.busy = (link_phase != PH_IDLE);
		s.done = done;
		s.read_data = last_byte;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_total++;
		end
	endtask

	// watch config writes, result words and input words
	always @(posedge clk or negedge arst_n) begin
		req_t    word_in;
		status_t want;
		status_t got;
		if (!arst_n) begin
			clock_half = CLOCK_HALF_RST;
			hold_wait = HOLD_WAIT_RST;
			rel_wait = RELEASE_WAIT_RST;
			link_phase = PH_IDLE;
			bits_left = 5'd0;
			ticks = 16'd0;
			frame = 16'd0;
			in_byte = 8'd0;
			last_byte = 8'd0;
			is_wr = 1'b0;
			clk_lvl = 1'b1;
			data_lvl = 1'b0;
			drive_lvl = 1'b1;
			pin_status_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLOCK_HALF:   clock_half = cfg_data[7:0];
					CFG_HOLD_WAIT:    hold_wait = cfg_data;
					CFG_RELEASE_WAIT: rel_wait = cfg_data;
					default: ;
				endcase
			end

			// result word against the oldest prediction
			if (out_valid && !out_stall) begin
				got = '{clock_pin, data_pin_out, data_drive, busy_res, done_res, read_data};
				if (pin_status_q.size() == 0) begin
					$error("result word with no prediction waiting");
					mismatch_total++;
				end else begin
					want = pin_status_q.pop_front();
					check_field("clock_pin", 8'(want.clock_pin), 8'(got.clock_pin));
					check_field("data_pin_out", 8'(want.data_pin_out), 8'(got.data_pin_out));
					check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
					check_field("busy_res", 8'(want.busy), 8'(got.busy));
					check_field("done_res", 8'(want.done), 8'(got.done));
					check_field("read_data", want.read_data, got.read_data);
				end
			end

			if (in_valid && !in_stall) begin
				word_in = '{start_req, func, reg_address, write_data, data_pin_in};
				advance_link(word_in, want);
				pin_status_q.push_back(want);
			end

			pending <= pin_status_q.size();
			fail_count <= mismatch_total;
		end
	end

endmodule

/* tb/tb_top.sv */
// top of the two-wire serial master testbench: clock, reset, config writes and tick words
// with random idling on both channels; verdict from the checker's failure count
// depends on twss_pkg, two_wire_sensor_serial_master_core, twss_link_checker
module tb_top;
	import twss_pkg::*;

	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = CFG_CLOCK_HALF;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                start_req = 1'b0;
	logic                func = 1'b0;
	logic [6:0]          reg_address = 7'd0;
	logic [7:0]          write_data = 8'd0;
	logic                data_pin_in = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                clock_pin;
	logic                data_pin_out;
	logic                data_drive;
	logic                busy_res;
	logic                done_res;
	logic [7:0]          read_data;
	int unsigned         fail_count;
	int unsigned         pending;

	// idling switch and the timing last programmed
	bit          gaps_on = 1'b1;
	int unsigned cur_half = CLOCK_HALF_RST;
	int unsigned cur_hold = HOLD_WAIT_RST;
	int unsigned cur_rel = RELEASE_WAIT_RST;
	int unsigned words_sent = 0;
	int unsigned stall_left = 0;

	two_wire_sensor_serial_master_core dut (.*);
	twss_link_checker checker_i (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side stalls in bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic din_level(input int unsigned one_pct);
		return $urandom_range(0, 99) < one_pct;
	endfunction

	function automatic logic [15:0] short_wait();
		return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
	endfunction

	// one tick word, held until taken
	task automatic send_tick(input logic st, input logic fn, input logic [6:0] ad,
			input logic [7:0] wd, input logic di);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= st;
		func <= fn;
		reg_address <= ad;
		write_data <= wd;
		data_pin_in <= di;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// random tick words, start asserted at the given rate
	task automatic run_ticks(input int unsigned n, input int unsigned start_pct);
		repeat (n) begin
			send_tick($urandom_range(0, 99) < start_pct, 1'($urandom), 7'($urandom),
				8'($urandom), 1'($urandom));
		end
	endtask

	// one complete access plus a couple of idle ticks
	task automatic run_access(input logic fn, input logic [6:0] ad, input logic [7:0] wd,
			input int unsigned one_pct);
		int unsigned span;
		span = 32 * cur_half + (fn ? 0 : cur_hold + cur_rel) + 2;
		send_tick(1'b1, fn, ad, wd, din_level(one_pct));
		repeat (span) begin
			send_tick(1'b0, 1'($urandom), 7'($urandom), 8'($urandom), din_level(one_pct));
		end
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// all timing registers, then a write to the unused index
	task automatic program_timing(input logic [7:0] half, input logic [15:0] hold,
			input logic [15:0] rel);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLOCK_HALF;
		cfg_data <= {8'($urandom), half};
		@(posedge clk);
		cfg_index <= CFG_HOLD_WAIT;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= CFG_RELEASE_WAIT;
		cfg_data <= rel;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_half = (half == 8'd0) ? 1 : half;
		cur_hold = hold;
		cur_rel = rel;
	endtask

	// timeout
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int unsigned target;
		int unsigned pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: write with all-ones fields
		run_access(1'b1, 7'h7F, 8'hFF, 50);

		// shortest half, zero waits
		settle();
		program_timing(8'd1, 16'd0, 16'd0);
		run_access(1'b1, 7'h00, 8'h00, 0);
		run_access(1'b0, 7'h7F, 8'hFF, 100);
		run_access(1'b0, 7'h55, 8'h00, 0);

		// zero half, one-tick waits, then a run with start held on every tick
		settle();
		program_timing(8'd0, 16'd1, 16'd1);
		run_access(1'b0, 7'h2A, 8'h00, 50);
		run_access(1'b1, 7'h55, 8'hAA, 50);
		run_ticks(120, 100);

		// random timings, mostly whole accesses with some noise and pauses
		for (int p = 0; p < 4; p++) begin
			settle();
			program_timing(8'($urandom_range(0, 3)), short_wait(), short_wait());
			target = words_sent + 200;
			while (words_sent < target) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					settle();
				end else if (pick < 5) begin
					run_ticks($urandom_range(1, 12), 40);
				end else begin
					run_access(1'($urandom), 7'($urandom), 8'($urandom),
						$urandom_range(0, 100));
				end
			end
		end

		// longest settings, no idling from here on
		gaps_on = 1'b0;
		settle();
		program_timing(8'd255, 16'hFFFF, 16'hFFFF);
		// opening part of a read with the longest half, starts ignored while busy
		send_tick(1'b1, 1'b0, 7'($urandom), 8'($urandom), 1'b0);
		run_ticks(100, 100);

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
